/* hw/rtl/evae_pkg.sv */
// Package: widths, codes and shared types of the encoder velocity/acceleration estimator
`default_nettype none

package evae_pkg;

   localparam int COUNT_WIDTH   = 32;
   localparam int FRACTION_BITS = 16;
   localparam int DATA_W        = 48;
   localparam int SCALE_SHIFT   = 32 - FRACTION_BITS;
   localparam int ALPHA_SHIFT   = 16;
   localparam int DIGIT_W       = 16;
   localparam int MAG_W         = 64;
   localparam int MULT_W        = 32;
   localparam int ACC_W         = MAG_W + MULT_W;
   localparam int DIGITS        = MAG_W / DIGIT_W;
   localparam int CNT_W         = $clog2(DIGITS);
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;
   localparam int RATE_W        = 16;
   localparam int ALPHA_W       = 16;

   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [MAG_W-1:0]         mag_type;
   typedef logic [ACC_W-1:0]         acc_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic {
      OP_STEP = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_RAD_PER_COUNT = 2'd0,
      REG_SAMPLE_RATE   = 2'd1,
      REG_VEL_ALPHA     = 2'd2,
      REG_ACC_ALPHA     = 2'd3
   } csr_reg_type;

   localparam logic [MULT_W-1:0]  RST_RAD_PER_COUNT = 32'd3294199;
   localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE   = 16'd500;
   localparam logic [ALPHA_W-1:0] RST_VEL_ALPHA     = 16'd3277;
   localparam logic [ALPHA_W-1:0] RST_ACC_ALPHA     = 16'd19661;

   typedef struct packed {
      logic [MULT_W-1:0]  rad_per_count;
      logic [RATE_W-1:0]  sample_rate_hz;
      logic [ALPHA_W-1:0] velocity_alpha;
      logic [ALPHA_W-1:0] acceleration_alpha;
   } cfg_type;

   typedef enum logic [1:0] {
      RND_NONE  = 2'd0,
      RND_SCALE = 2'd1,
      RND_ALPHA = 2'd2
   } rnd_type;

   typedef struct packed {
      logic              start;
      logic              neg;
      rnd_type           rnd;
      mag_type           a_mag;
      logic [MULT_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic     done;
      data_type result;
      mag_type  mag;
   } mul_rsp_type;

   typedef enum logic [1:0] {
      MUL_IDLE  = 2'd0,
      MUL_DIGIT = 2'd1,
      MUL_ROUND = 2'd2
   } mul_phase_type;

   typedef enum logic [2:0] {
      SEQ_IDLE = 3'd0,
      SEQ_POS  = 3'd1,
      SEQ_DR   = 3'd2,
      SEQ_VEL  = 3'd3,
      SEQ_ACC  = 3'd4,
      SEQ_VFLT = 3'd5,
      SEQ_AFLT = 3'd6,
      SEQ_OUT  = 3'd7
   } seq_state_type;

endpackage

`default_nettype wire

/* hw/rtl/evae_if.sv */
// Interfaces: request and response channels of the estimator
`default_nettype none

interface evae_req_if;
   logic valid;
   logic ready;
   logic opcode;
   logic step_up;

   modport source (output valid, output opcode, output step_up, input ready);
   modport sink (input valid, input opcode, input step_up, output ready);
endinterface

interface evae_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [evae_pkg::DATA_W-1:0] position_rad;
   logic signed [evae_pkg::DATA_W-1:0] velocity_rad_s;
   logic signed [evae_pkg::DATA_W-1:0] acceleration_rad_s2;

   modport source (output valid, output position_rad, output velocity_rad_s,
                   output acceleration_rad_s2, input ready);
   modport sink (input valid, input position_rad, input velocity_rad_s,
                 input acceleration_rad_s2, output ready);
endinterface

`default_nettype wire

/* hw/rtl/evae_csr.sv */
// Configuration registers behind the APB-style port
`default_nettype none

module evae_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [1:0]                        csr_reg_sel,
   input  logic [evae_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [evae_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output evae_pkg::cfg_type                 cfg
);

   evae_pkg::cfg_type     cfg_ff;
   evae_pkg::cfg_type     cfg_in;
   evae_pkg::csr_reg_type sel;
   logic                  wr_en;

   assign sel        = evae_pkg::csr_reg_type'(csr_reg_sel);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (sel)
            evae_pkg::REG_RAD_PER_COUNT:
               cfg_in.rad_per_count = csr_pwdata[evae_pkg::MULT_W-1:0];
            evae_pkg::REG_SAMPLE_RATE:
               cfg_in.sample_rate_hz = csr_pwdata[evae_pkg::RATE_W-1:0];
            evae_pkg::REG_VEL_ALPHA:
               cfg_in.velocity_alpha = csr_pwdata[evae_pkg::ALPHA_W-1:0];
            evae_pkg::REG_ACC_ALPHA:
               cfg_in.acceleration_alpha = csr_pwdata[evae_pkg::ALPHA_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         evae_pkg::REG_RAD_PER_COUNT:
            csr_prdata = evae_pkg::CSR_DATA_W'(cfg_ff.rad_per_count);
         evae_pkg::REG_SAMPLE_RATE:
            csr_prdata = evae_pkg::CSR_DATA_W'(cfg_ff.sample_rate_hz);
         evae_pkg::REG_VEL_ALPHA:
            csr_prdata = evae_pkg::CSR_DATA_W'(cfg_ff.velocity_alpha);
         evae_pkg::REG_ACC_ALPHA:
            csr_prdata = evae_pkg::CSR_DATA_W'(cfg_ff.acceleration_alpha);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rad_per_count      <= evae_pkg::RST_RAD_PER_COUNT;
         cfg_ff.sample_rate_hz     <= evae_pkg::RST_SAMPLE_RATE;
         cfg_ff.velocity_alpha     <= evae_pkg::RST_VEL_ALPHA;
         cfg_ff.acceleration_alpha <= evae_pkg::RST_ACC_ALPHA;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/evae_mul.sv */
// Shared multiplier: digit-serial 64x32 product, rounding, sign and 48-bit saturation
`default_nettype none

module evae_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  evae_pkg::mul_req_type req,
   output evae_pkg::mul_rsp_type rsp
);

   evae_pkg::mul_phase_type          phase_ff, phase_in;
   logic [evae_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                             done_ff, done_in;
   evae_pkg::mag_type                a_ff, a_in;
   logic [evae_pkg::MULT_W-1:0]      b_ff, b_in;
   logic                             neg_ff, neg_in;
   evae_pkg::rnd_type                rnd_ff, rnd_in;
   evae_pkg::acc_type                acc_ff, acc_in;
   evae_pkg::data_type               res_ff, res_in;
   evae_pkg::mag_type                mag_ff, mag_in;

   logic [evae_pkg::DIGIT_W+evae_pkg::MULT_W-1:0] pp;
   evae_pkg::acc_type                acc_step;
   evae_pkg::acc_type                rounded;
   logic                             big;
   logic [evae_pkg::DATA_W-1:0]      low;
   evae_pkg::data_type               sat_res;

   // top digit first, so the accumulator only ever shifts left by one digit
   assign pp = a_ff[evae_pkg::MAG_W-1 -: evae_pkg::DIGIT_W] * b_ff;
   assign acc_step = {acc_ff[evae_pkg::ACC_W-evae_pkg::DIGIT_W-1:0],
                      {evae_pkg::DIGIT_W{1'b0}}} + evae_pkg::ACC_W'(pp);

   always_comb begin
      case (rnd_ff)
         evae_pkg::RND_SCALE:
            rounded = (acc_ff + (evae_pkg::ACC_W'(1) << (evae_pkg::SCALE_SHIFT - 1)))
                      >> evae_pkg::SCALE_SHIFT;
         evae_pkg::RND_ALPHA:
            rounded = (acc_ff + (evae_pkg::ACC_W'(1) << (evae_pkg::ALPHA_SHIFT - 1)))
                      >> evae_pkg::ALPHA_SHIFT;
         default:
            rounded = acc_ff;
      endcase
   end

   // saturate on magnitude, then apply sign
   assign big = |rounded[evae_pkg::ACC_W-1:evae_pkg::DATA_W-1];
   assign low = rounded[evae_pkg::DATA_W-1:0];

   always_comb begin
      if (big) begin
         sat_res = neg_ff ? evae_pkg::DATA_MIN : evae_pkg::DATA_MAX;
      end else if (neg_ff) begin
         sat_res = evae_pkg::data_type'(-low);
      end else begin
         sat_res = evae_pkg::data_type'(low);
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      a_in     = a_ff;
      b_in     = b_ff;
      neg_in   = neg_ff;
      rnd_in   = rnd_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      mag_in   = mag_ff;
      unique case (phase_ff)
         evae_pkg::MUL_IDLE: begin
            if (req.start) begin
               a_in     = req.a_mag;
               b_in     = req.b;
               neg_in   = req.neg;
               rnd_in   = req.rnd;
               acc_in   = '0;
               cnt_in   = '0;
               phase_in = evae_pkg::MUL_DIGIT;
            end
         end
         evae_pkg::MUL_DIGIT: begin
            acc_in = acc_step;
            a_in   = a_ff << evae_pkg::DIGIT_W;
            cnt_in = cnt_ff + evae_pkg::CNT_W'(1);
            if (cnt_ff == evae_pkg::CNT_W'(evae_pkg::DIGITS - 1)) begin
               phase_in = evae_pkg::MUL_ROUND;
            end
         end
         evae_pkg::MUL_ROUND: begin
            res_in   = sat_res;
            mag_in   = rounded[evae_pkg::MAG_W-1:0];
            done_in  = 1'b1;
            phase_in = evae_pkg::MUL_IDLE;
         end
         default: begin
            phase_in = evae_pkg::MUL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= evae_pkg::MUL_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      neg_ff <= neg_in;
      rnd_ff <= rnd_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      mag_ff <= mag_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;
   assign rsp.mag    = mag_ff;

endmodule

`default_nettype wire

/* hw/rtl/encoder_velocity_accel_estimator.sv */
// Top level: encoder count, tick sequencer, filters and result register
//
// Step events (opcode 0) move a wrapping 32-bit signed count, with no result.
// A sample tick (opcode 1) runs six products through one shared multiplier
// (16x32 bits a cycle, four digit passes plus a rounding step): position,
// count change times rate, instantaneous velocity, instantaneous acceleration
// and the two low-pass updates. A tick holds the request side from acceptance
// until its result is loaded into the output register, which waits until the
// previous result word has been taken. Results sit in an output register, so
// step events keep being accepted while a result waits. All outputs are signed
// Q32.16, rounded to nearest (ties away from zero) and saturated to 48 bits.
// Configuration must be written while the block is idle; it is not enforced.
`default_nettype none

module encoder_velocity_accel_estimator (
   input  logic                                clock,
   input  logic                                reset,
   evae_req_if.sink                            req_chan,
   evae_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [evae_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [evae_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [evae_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int DW = evae_pkg::DATA_W;
   localparam int CW = evae_pkg::COUNT_WIDTH;

   function automatic evae_pkg::data_type sat_add(evae_pkg::data_type y,
                                                  evae_pkg::data_type r);
      logic signed [DW:0] s;
      s = {y[DW-1], y} + {r[DW-1], r};
      if (s[DW] != s[DW-1]) begin
         return s[DW] ? evae_pkg::DATA_MIN : evae_pkg::DATA_MAX;
      end
      return s[DW-1:0];
   endfunction

   evae_pkg::cfg_type       cfg;
   evae_pkg::mul_req_type   mul_req;
   evae_pkg::mul_rsp_type   mul_rsp;

   evae_pkg::seq_state_type state_ff, state_in;
   evae_pkg::count_type     count_ff, count_in;
   evae_pkg::count_type     last_ff, last_in;
   evae_pkg::data_type      vf_ff, vf_in;
   evae_pkg::data_type      af_ff, af_in;
   evae_pkg::data_type      ainst_ff, ainst_in;
   evae_pkg::data_type      pos_ff, pos_in;
   logic [DW:0]             dmag_ff, dmag_in;
   logic                    dneg_ff, dneg_in;
   logic                    dlt_neg_ff, dlt_neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   evae_pkg::data_type      rsp_pos_ff, rsp_pos_in;
   evae_pkg::data_type      rsp_vel_ff, rsp_vel_in;
   evae_pkg::data_type      rsp_acc_ff, rsp_acc_in;

   logic                    accept;
   logic                    last_neg;
   evae_pkg::count_type     last_mag;
   evae_pkg::count_type     delta;
   logic                    delta_neg;
   evae_pkg::count_type     delta_mag;
   logic signed [DW:0]      vdiff;
   logic [DW:0]             vdiff_mag;
   logic signed [DW:0]      adiff;
   logic [DW:0]             adiff_mag;

   evae_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_reg_sel (csr_paddr[3:2]),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   evae_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   assign req_chan.ready = (state_ff == evae_pkg::SEQ_IDLE);
   assign accept         = req_chan.valid & req_chan.ready;

   assign last_neg  = last_ff[CW-1];
   assign last_mag  = last_neg ? -last_ff : last_ff;
   assign delta     = count_ff - last_ff;
   assign delta_neg = delta[CW-1];
   assign delta_mag = delta_neg ? -delta : delta;

   // velocity error against the filter value before this tick
   assign vdiff     = {mul_rsp.result[DW-1], mul_rsp.result} - {vf_ff[DW-1], vf_ff};
   assign vdiff_mag = vdiff[DW] ? -vdiff : vdiff;
   assign adiff     = {ainst_ff[DW-1], ainst_ff} - {af_ff[DW-1], af_ff};
   assign adiff_mag = adiff[DW] ? -adiff : adiff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      vf_in        = vf_ff;
      af_in        = af_ff;
      ainst_in     = ainst_ff;
      pos_in       = pos_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      dlt_neg_in   = dlt_neg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_acc_in   = rsp_acc_ff;
      mul_req.start = 1'b0;
      mul_req.neg   = 1'b0;
      mul_req.rnd   = evae_pkg::RND_NONE;
      mul_req.a_mag = '0;
      mul_req.b     = '0;

      unique case (state_ff)
         evae_pkg::SEQ_IDLE: begin
            if (accept) begin
               if (req_chan.opcode == evae_pkg::OP_TICK) begin
                  mul_req.start = 1'b1;
                  mul_req.neg   = last_neg;
                  mul_req.rnd   = evae_pkg::RND_SCALE;
                  mul_req.a_mag = evae_pkg::MAG_W'(last_mag);
                  mul_req.b     = cfg.rad_per_count;
                  state_in      = evae_pkg::SEQ_POS;
               end else if (req_chan.step_up) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
         end
         evae_pkg::SEQ_POS: begin
            if (mul_rsp.done) begin
               pos_in        = mul_rsp.result;
               dlt_neg_in    = delta_neg;
               last_in       = count_ff;
               mul_req.start = 1'b1;
               mul_req.neg   = delta_neg;
               mul_req.rnd   = evae_pkg::RND_NONE;
               mul_req.a_mag = evae_pkg::MAG_W'(delta_mag);
               mul_req.b     = evae_pkg::MULT_W'(cfg.sample_rate_hz);
               state_in      = evae_pkg::SEQ_DR;
            end
         end
         evae_pkg::SEQ_DR: begin
            // raw count change times rate, no rounding
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.neg   = dlt_neg_ff;
               mul_req.rnd   = evae_pkg::RND_SCALE;
               mul_req.a_mag = mul_rsp.mag;
               mul_req.b     = cfg.rad_per_count;
               state_in      = evae_pkg::SEQ_VEL;
            end
         end
         evae_pkg::SEQ_VEL: begin
            if (mul_rsp.done) begin
               dmag_in       = vdiff_mag;
               dneg_in       = vdiff[DW];
               mul_req.start = 1'b1;
               mul_req.neg   = vdiff[DW];
               mul_req.rnd   = evae_pkg::RND_NONE;
               mul_req.a_mag = evae_pkg::MAG_W'(vdiff_mag);
               mul_req.b     = evae_pkg::MULT_W'(cfg.sample_rate_hz);
               state_in      = evae_pkg::SEQ_ACC;
            end
         end
         evae_pkg::SEQ_ACC: begin
            if (mul_rsp.done) begin
               ainst_in      = mul_rsp.result;
               mul_req.start = 1'b1;
               mul_req.neg   = dneg_ff;
               mul_req.rnd   = evae_pkg::RND_ALPHA;
               mul_req.a_mag = evae_pkg::MAG_W'(dmag_ff);
               mul_req.b     = evae_pkg::MULT_W'(cfg.velocity_alpha);
               state_in      = evae_pkg::SEQ_VFLT;
            end
         end
         evae_pkg::SEQ_VFLT: begin
            if (mul_rsp.done) begin
               vf_in         = sat_add(vf_ff, mul_rsp.result);
               mul_req.start = 1'b1;
               mul_req.neg   = adiff[DW];
               mul_req.rnd   = evae_pkg::RND_ALPHA;
               mul_req.a_mag = evae_pkg::MAG_W'(adiff_mag);
               mul_req.b     = evae_pkg::MULT_W'(cfg.acceleration_alpha);
               state_in      = evae_pkg::SEQ_AFLT;
            end
         end
         evae_pkg::SEQ_AFLT: begin
            if (mul_rsp.done) begin
               af_in    = sat_add(af_ff, mul_rsp.result);
               state_in = evae_pkg::SEQ_OUT;
            end
         end
         evae_pkg::SEQ_OUT: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff;
               rsp_vel_in   = vf_ff;
               rsp_acc_in   = af_ff;
               state_in     = evae_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = evae_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= evae_pkg::SEQ_IDLE;
         count_ff     <= '0;
         last_ff      <= '0;
         vf_ff        <= '0;
         af_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         vf_ff        <= vf_in;
         af_ff        <= af_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ainst_ff   <= ainst_in;
      pos_ff     <= pos_in;
      dmag_ff    <= dmag_in;
      dneg_ff    <= dneg_in;
      dlt_neg_ff <= dlt_neg_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_vel_ff <= rsp_vel_in;
      rsp_acc_ff <= rsp_acc_in;
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.position_rad        = rsp_pos_ff;
   assign rsp_chan.velocity_rad_s      = rsp_vel_ff;
   assign rsp_chan.acceleration_rad_s2 = rsp_acc_ff;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Testbench: random and directed step/tick words checked against a built-in estimator predictor
`timescale 1ns / 100ps

module tb;
   import evae_pkg::*;

   typedef struct packed {
      op_type op;
      logic   up;
   } enc_event_type;

   typedef struct packed {
      data_type pos;
      data_type vel;
      data_type acc;
   } tick_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   evae_req_if req_if ();
   evae_rsp_if rsp_if ();

   encoder_velocity_accel_estimator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor copy of registers and state
   cfg_type   est_cfg;
   count_type enc_count;
   count_type last_tick_count;
   data_type  vel_flt;
   data_type  acc_flt;

   enc_event_type   event_q[$];
   tick_result_type awaited_q[$];

   int send_idle_pct;
   int recv_idle_pct;
   int n_words;
   int n_ticks;
   int n_checked;
   int n_errors;
   int n_settings;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // round to nearest (ties away from zero) on the magnitude, then saturate to 48 bits
   function automatic data_type round_scale_sat(input logic neg, input mag_type mag,
                                                input logic [MULT_W-1:0] mul,
                                                input int unsigned sh);
      logic [127:0] prod;
      prod = {64'd0, mag} * {96'd0, mul};
      if (sh > 0) prod = prod + (128'd1 << (sh - 1));
      prod = prod >> sh;
      if (prod >= (128'd1 << (DATA_W - 1))) return neg ? DATA_MIN : DATA_MAX;
      return neg ? -data_type'(prod[DATA_W-1:0]) : data_type'(prod[DATA_W-1:0]);
   endfunction

   function automatic mag_type diff_mag(input data_type a, input data_type b, output logic neg);
      longint d;
      d = longint'(a) - longint'(b);
      neg = d < 0;
      return neg ? mag_type'(-d) : mag_type'(d);
   endfunction

   function automatic mag_type count_mag(input count_type c, output logic neg);
      neg = c[COUNT_WIDTH-1];
      return neg ? mag_type'(count_type'(-c)) : mag_type'(c);
   endfunction

   function automatic data_type lowpass(input data_type y, input data_type x,
                                        input logic [ALPHA_W-1:0] alpha);
      logic    neg;
      mag_type mag;
      longint  s;
      mag = diff_mag(x, y, neg);
      s = longint'(y) + longint'(round_scale_sat(neg, mag, {16'd0, alpha}, ALPHA_SHIFT));
      if (s > longint'(DATA_MAX)) return DATA_MAX;
      if (s < longint'(DATA_MIN)) return DATA_MIN;
      return data_type'(s);
   endfunction

   // advances the estimator by one word; returns 1 when a tick yields a result
   function automatic logic track_event(input enc_event_type ev, output tick_result_type res);
      logic     neg;
      mag_type  mag;
      data_type v_now;
      data_type a_now;
      if (ev.op == OP_STEP) begin
         enc_count = ev.up ? enc_count + 1'b1 : enc_count - 1'b1;
         return 1'b0;
      end
      mag = count_mag(last_tick_count, neg);
      res.pos = round_scale_sat(neg, mag, est_cfg.rad_per_count, SCALE_SHIFT);
      mag = count_mag(enc_count - last_tick_count, neg);
      last_tick_count = enc_count;
      v_now = round_scale_sat(neg, mag * est_cfg.sample_rate_hz, est_cfg.rad_per_count,
                              SCALE_SHIFT);
      // acceleration uses the filtered velocity from before this tick
      mag = diff_mag(v_now, vel_flt, neg);
      a_now = round_scale_sat(neg, mag, {16'd0, est_cfg.sample_rate_hz}, 0);
      vel_flt = lowpass(vel_flt, v_now, est_cfg.velocity_alpha);
      acc_flt = lowpass(acc_flt, a_now, est_cfg.acceleration_alpha);
      res.vel = vel_flt;
      res.acc = acc_flt;
      return 1'b1;
   endfunction

   function automatic void check_field(input string what, input data_type want,
                                       input data_type got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         n_errors++;
      end
   endfunction

   function automatic void push_event(input op_type op, input logic up);
      event_q.push_back('{op: op, up: up});
   endfunction

   always @(posedge clock) begin : req_driver
      enc_event_type   nxt;
      tick_result_type res;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            n_words++;
            if (track_event('{op: op_type'(req_if.opcode), up: req_if.step_up}, res)) begin
               awaited_q.push_back(res);
               n_ticks++;
            end
         end
         if (!req_if.valid || req_if.ready) begin
            if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = event_q.pop_front();
               req_if.valid   <= 1'b1;
               req_if.opcode  <= nxt.op;
               req_if.step_up <= nxt.up;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      tick_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_q.size() == 0) begin
               $display("%0t ns: result word with none expected, expected nothing, got %0d %0d %0d",
                        $time, rsp_if.position_rad, rsp_if.velocity_rad_s,
                        rsp_if.acceleration_rad_s2);
               n_errors++;
            end else begin
               want = awaited_q.pop_front();
               check_field("position", want.pos, rsp_if.position_rad);
               check_field("velocity", want.vel, rsp_if.velocity_rad_s);
               check_field("acceleration", want.acc, rsp_if.acceleration_rad_s2);
               n_checked++;
            end
         end
         rsp_if.ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // a step word never yields a result, so allow the tick latency once drained
   task automatic wait_idle();
      while (event_q.size() != 0 || req_if.valid || awaited_q.size() != 0)
         @(negedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type r, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (r)
         REG_RAD_PER_COUNT: est_cfg.rad_per_count = val;
         REG_SAMPLE_RATE:   est_cfg.sample_rate_hz = val[RATE_W-1:0];
         REG_VEL_ALPHA:     est_cfg.velocity_alpha = val[ALPHA_W-1:0];
         REG_ACC_ALPHA:     est_cfg.acceleration_alpha = val[ALPHA_W-1:0];
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // mostly runs of steps closed by a tick, with some loose words mixed in
   task automatic queue_random(input int n_items);
      int   added;
      int   run;
      int   i;
      logic dir;
      added = 0;
      while (added < n_items) begin
         if ($urandom_range(9) < 8) begin
            run = ($urandom_range(7) == 0) ? $urandom_range(30, 90) : $urandom_range(0, 12);
            dir = 1'($urandom_range(1));
            for (i = 0; i < run; i++)
               push_event(OP_STEP, ($urandom_range(9) < 8) ? dir : !dir);
            push_event(OP_TICK, 1'($urandom_range(1)));
            added += run + 1;
         end else begin
            push_event(op_type'($urandom_range(1)), 1'($urandom_range(1)));
            added++;
         end
      end
   endtask

   task automatic run_phase(input logic [31:0] rpc, input logic [15:0] rate,
                            input logic [15:0] va, input logic [15:0] aa,
                            input int n_items, input int mode);
      wait_idle();
      write_reg(REG_RAD_PER_COUNT, rpc);
      write_reg(REG_SAMPLE_RATE, {16'($urandom()), rate});
      write_reg(REG_VEL_ALPHA, {16'($urandom()), va});
      write_reg(REG_ACC_ALPHA, {16'($urandom()), aa});
      n_settings++;
      case (mode)
         0: begin
            send_idle_pct = 34;
            recv_idle_pct = 59;
         end
         1: begin
            send_idle_pct = 59;
            recv_idle_pct = 34;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
      @(negedge clock);
      queue_random(n_items);
   endtask

   initial begin : stimulus
      reset          <= 1'b1;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      est_cfg = '{RST_RAD_PER_COUNT, RST_SAMPLE_RATE, RST_VEL_ALPHA, RST_ACC_ALPHA};
      enc_count = '0;
      last_tick_count = '0;
      vel_flt = '0;
      acc_flt = '0;
      n_words = 0;
      n_ticks = 0;
      n_checked = 0;
      n_errors = 0;
      n_settings = 1;
      send_idle_pct = 34;
      recv_idle_pct = 59;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: tick from rest, single steps, negative count, repeated ticks
      push_event(OP_TICK, 1'b0);
      push_event(OP_STEP, 1'b1);
      push_event(OP_TICK, 1'b0);
      repeat (3) push_event(OP_STEP, 1'b0);
      push_event(OP_TICK, 1'b0);
      push_event(OP_TICK, 1'b1);
      repeat (6) push_event(OP_STEP, 1'b1);
      push_event(OP_TICK, 1'b1);
      push_event(OP_STEP, 1'b0);
      push_event(OP_STEP, 1'b1);
      push_event(OP_STEP, 1'b1);
      push_event(OP_TICK, 1'b0);
      push_event(OP_TICK, 1'b1);

      run_phase(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 100, 0);
      run_phase(32'h0000_0000, 16'd1, 16'h0000, 16'hFFFF, 40, 0);
      // zero rate: instantaneous values collapse to zero
      run_phase($urandom(), 16'd0, 16'($urandom()), 16'($urandom()), 60, 1);
      run_phase($urandom(), 16'($urandom_range(1, 65535)), 16'($urandom()),
                16'($urandom()), 120, 1);
      run_phase(RST_RAD_PER_COUNT, RST_SAMPLE_RATE, RST_VEL_ALPHA, RST_ACC_ALPHA, 120, 2);
      run_phase($urandom(), 16'($urandom_range(1, 65535)), 16'($urandom()),
                16'($urandom()), 120, 2);
      wait_idle();

      $display("Drove %0d step/tick words (%0d ticks) over %0d register settings;",
               n_words, n_ticks, n_settings);
      $display("checked %0d result words, %0d mismatches.", n_checked, n_errors);
      if (n_errors == 0) begin
         $display("[encoder_velocity_accel_estimator] OK");
      end else begin
         $display("[encoder_velocity_accel_estimator] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("[encoder_velocity_accel_estimator] ERROR");
      $finish;
   end

endmodule
